@@ hdl/lbmc_pkg.sv @@
// Package for the D3Q27 BGK node collision block.
// Holds widths, state codes, lattice tables and saturation helpers.
// No dependencies.
package lbmc_pkg;

  localparam int FRAC_BITS = 24;
  localparam int NDIR      = 27;
  localparam int DIR_W     = 5;
  localparam int RATE_W    = 26;
  localparam int ACC_W     = 37;           // sum of 27 signed 32-bit values
  localparam int MUL_W     = 33;           // shared multiplier operand width
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DVD_W     = 32 + FRAC_BITS;
  localparam int CNT_W     = $clog2(DVD_W);
  localparam int SQ_W      = 64 - FRAC_BITS;
  localparam int POLY_W    = 48;

  localparam logic [RATE_W-1:0] RELAX_RESET =
    RATE_W'(((64'd2000 << FRAC_BITS) + 64'd501) / 64'd1003);

  // divide by 27 in two digits: reciprocals for an 18-bit and a 23-bit dividend
  localparam logic [18:0] RECIP_HI = 19'd310690;     // ceil(2^23 / 27)
  localparam logic [23:0] RECIP_LO = 24'd9942054;    // ceil(2^28 / 27)

  localparam logic [DIR_W-1:0] LAST_DIR = DIR_W'(NDIR - 1);

  // sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SUM_RD   = 5'd1;
  localparam logic [4:0] S_SUM_ACC  = 5'd2;
  localparam logic [4:0] S_MOM      = 5'd3;
  localparam logic [4:0] S_DIV_GO   = 5'd4;
  localparam logic [4:0] S_DIV_WAIT = 5'd5;
  localparam logic [4:0] S_UU_MUL   = 5'd6;
  localparam logic [4:0] S_UU_ACC   = 5'd7;
  localparam logic [4:0] S_D_RD     = 5'd8;
  localparam logic [4:0] S_D_EU2    = 5'd9;
  localparam logic [4:0] S_D_POLY   = 5'd10;
  localparam logic [4:0] S_D_RMUL   = 5'd11;
  localparam logic [4:0] S_D_FEABS  = 5'd12;
  localparam logic [4:0] S_D_FEHI   = 5'd13;
  localparam logic [4:0] S_D_FELO   = 5'd14;
  localparam logic [4:0] S_D_OMUL   = 5'd15;
  localparam logic [4:0] S_D_RES    = 5'd16;

  typedef struct packed {
    logic [1:0] x;
    logic [1:0] y;
    logic [1:0] z;
  } dir_vec_t;

  localparam logic [1:0] CP = 2'b01;   // +1
  localparam logic [1:0] CN = 2'b11;   // -1
  localparam logic [1:0] CZ = 2'b00;

  function automatic dir_vec_t dir_vec(input logic [DIR_W-1:0] j);
    dir_vec_t d;
    case (j)
      5'd0:    d = '{CZ, CZ, CZ};
      5'd1:    d = '{CP, CZ, CZ};
      5'd2:    d = '{CZ, CP, CZ};
      5'd3:    d = '{CN, CZ, CZ};
      5'd4:    d = '{CZ, CN, CZ};
      5'd5:    d = '{CZ, CZ, CP};
      5'd6:    d = '{CZ, CZ, CN};
      5'd7:    d = '{CP, CP, CZ};
      5'd8:    d = '{CN, CP, CZ};
      5'd9:    d = '{CN, CN, CZ};
      5'd10:   d = '{CP, CN, CZ};
      5'd11:   d = '{CP, CZ, CP};
      5'd12:   d = '{CZ, CP, CP};
      5'd13:   d = '{CN, CZ, CP};
      5'd14:   d = '{CZ, CN, CP};
      5'd15:   d = '{CP, CZ, CN};
      5'd16:   d = '{CZ, CP, CN};
      5'd17:   d = '{CN, CZ, CN};
      5'd18:   d = '{CZ, CN, CN};
      5'd19:   d = '{CP, CP, CP};
      5'd20:   d = '{CN, CP, CP};
      5'd21:   d = '{CN, CN, CP};
      5'd22:   d = '{CP, CN, CP};
      5'd23:   d = '{CP, CP, CN};
      5'd24:   d = '{CN, CP, CN};
      5'd25:   d = '{CN, CN, CN};
      5'd26:   d = '{CP, CN, CN};
      default: d = '{CZ, CZ, CZ};
    endcase
    return d;
  endfunction

  // weight = 2^shift / 216
  function automatic logic [2:0] weight_shift(input logic [DIR_W-1:0] j);
    logic [2:0] s;
    if (j == '0) s = 3'd6;
    else if (j inside {[5'd1:5'd6]}) s = 3'd4;
    else if (j inside {[5'd7:5'd18]}) s = 3'd2;
    else s = 3'd0;
    return s;
  endfunction

  // c * v for c in {-1, 0, 1}
  function automatic logic signed [33:0] dir_term(input logic [1:0] c,
                                                  input logic signed [31:0] v);
    logic signed [33:0] r;
    case (c)
      CP:      r = 34'(v);
      CN:      r = -34'(v);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > PROD_W'(64'sd2147483647)) r = 32'sh7fffffff;
    else if (v < -PROD_W'(64'sd2147483648)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // divide by 2^FRAC_BITS, truncating toward zero
  function automatic logic signed [PROD_W-1:0] trunc_frac(
      input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] bias;
    bias = p[PROD_W-1] ? PROD_W'((66'd1 << FRAC_BITS) - 66'd1) : '0;
    return (p + bias) >>> FRAC_BITS;
  endfunction

endpackage

@@ hdl/lbmc_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on lbmc_pkg.
module lbmc_mul (
  input  logic                              clk,
  input  logic signed [lbmc_pkg::MUL_W-1:0] op_a,
  input  logic signed [lbmc_pkg::MUL_W-1:0] op_b,
  output logic signed [lbmc_pkg::PROD_W-1:0] prod
);
  import lbmc_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

@@ hdl/lbmc_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on lbmc_pkg.
module lbmc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [lbmc_pkg::DVD_W-1:0] dividend,
  input  logic [31:0]                divisor,
  output logic                       busy,
  output logic                       done,
  output logic [lbmc_pkg::DVD_W-1:0] quotient
);
  import lbmc_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [31:0]      dvs_r;
  logic [32:0]      trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[DVD_W-1]} - {1'b0, dvs_r};
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[DVD_W-1]};
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (go) dvs_r <= divisor;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hdl/lbm_bgk_node_collision_top.sv @@
// D3Q27 BGK collision of one lattice node: top level with sequencer and store.
// Depends on lbmc_pkg, lbmc_mul, lbmc_div.
//
// Usage: feed the 27 distributions of a node one per item (start while busy
// is low), direction 0 first, last_of_node on the 27th. Items without
// last_of_node give no result. The last item starts the node computation
// and busy stays high while it runs; results come with out_strobe, one cycle
// each, in direction order, the last one in the first cycle that busy is low
// again. The receiver cannot stall them. After the last item a fluid node
// runs the moment sum, the saturation, the velocity divisions by density,
// the velocity square, then the collision of each direction. A node whose
// density is zero skips the divisions. A solid node passes its stored values
// out unchanged, a read and an output state per direction. One multiplier
// is shared by the squaring, density and relaxation products; a bit-serial
// divider serves the division by density only, the lattice weight divide
// by 216 is a shift plus two reciprocal-multiply digits.
// relax_rate may be written only while busy is low and no node is pending.
module lbm_bgk_node_collision_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [31:0]               in_dist_value,
  input  logic                             in_node_solid,
  input  logic                             in_last_of_node,
  input  logic                             cfg_we,
  input  logic [lbmc_pkg::RATE_W-1:0]      cfg_wdata,
  output logic                             out_strobe,
  output logic signed [31:0]               out_collided_value,
  output logic [lbmc_pkg::DIR_W-1:0]       out_direction_index,
  output logic signed [31:0]               out_density,
  output logic signed [31:0]               out_vel_x,
  output logic signed [31:0]               out_vel_y,
  output logic signed [31:0]               out_vel_z,
  output logic                             out_last_of_run
);
  import lbmc_pkg::*;

  // control
  logic [4:0]       state_r, state_nxt;
  logic [DIR_W-1:0] dir_count_r, dir_count_nxt;
  logic             solid_seen_r, solid_seen_nxt;
  logic             solid_r, solid_nxt;
  logic [DIR_W-1:0] idx_r, idx_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [RATE_W-1:0] relax_r;
  logic             strobe_r, strobe_nxt;
  logic             accept;

  // datapath
  logic signed [ACC_W-1:0] rho_acc_r, rho_acc_nxt;
  logic signed [ACC_W-1:0] mom_acc_r [3];
  logic signed [ACC_W-1:0] mom_acc_nxt [3];
  logic signed [31:0] rho_r, rho_nxt;
  logic signed [31:0] mom_r [3];
  logic signed [31:0] mom_nxt [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] vel_nxt [3];
  logic [SQ_W-1:0]    uu_r, uu_nxt;
  logic signed [33:0] eu_r, eu_nxt;
  logic signed [31:0] poly_r, poly_nxt;
  logic signed [31:0] fe_r, fe_nxt;
  logic               neg_r, neg_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic [DIR_W-1:0]   odir_r, odir_nxt;
  // weight divide: |t| * 2^shift / 8, then two base-2^18 digits of / 27
  logic [35:0]        fe_x_r, fe_x_nxt;
  logic               fe_big_r, fe_big_nxt;
  logic [13:0]        fe_qh_r, fe_qh_nxt;
  logic [22:0]        fe_rl_r, fe_rl_nxt;

  // store
  logic [31:0]      mem [NDIR];
  logic [31:0]      rd_data_r;
  logic             wr_en;
  logic signed [31:0] f_cur;

  // shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     div_go;
  logic [DVD_W-1:0]         div_dvd;
  logic [31:0]              div_dvs;
  logic                     div_busy, div_done;
  logic [DVD_W-1:0]         div_q;

  // scratch
  dir_vec_t                 dv;
  logic signed [33:0]       eu_abs;
  logic [31:0]              eu_mag;
  logic [31:0]              vmag;
  logic [SQ_W-1:0]          sq;
  logic [POLY_W-1:0]        nine_eu2, three_uu;
  logic signed [POLY_W-1:0] poly_w;
  logic signed [PROD_W-1:0] tq, tabs, qs, sub, res_w;
  logic signed [32:0]       diff;
  logic signed [31:0]       mom_sel;
  logic [31:0]              mom_mag, rho_mag;
  logic [PROD_W-1:0]        fe_xw;
  logic [36:0]              hq_p;
  logic [17:0]              rh_full;
  logic [46:0]              lq_p;
  logic [32:0]              fe_qm;

  lbmc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  lbmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (dir_count_r < DIR_W'(NDIR));
  assign f_cur  = rd_data_r;
  assign dv     = dir_vec(idx_r);

  // distribution store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[dir_count_r] <= in_dist_value;
    rd_data_r <= mem[idx_r];
  end

  always_comb begin
    state_nxt      = state_r;
    dir_count_nxt  = dir_count_r;
    solid_seen_nxt = solid_seen_r;
    solid_nxt      = solid_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    strobe_nxt     = 1'b0;
    rho_acc_nxt    = rho_acc_r;
    mom_acc_nxt    = mom_acc_r;
    rho_nxt        = rho_r;
    mom_nxt        = mom_r;
    vel_nxt        = vel_r;
    uu_nxt         = uu_r;
    eu_nxt         = eu_r;
    poly_nxt       = poly_r;
    fe_nxt         = fe_r;
    neg_nxt        = neg_r;
    res_nxt        = res_r;
    odir_nxt       = odir_r;
    fe_x_nxt       = fe_x_r;
    fe_big_nxt     = fe_big_r;
    fe_qh_nxt      = fe_qh_r;
    fe_rl_nxt      = fe_rl_r;
    mul_a          = '0;
    mul_b          = '0;
    div_go         = 1'b0;
    div_dvd        = '0;
    div_dvs        = '0;

    eu_abs   = eu_r[33] ? -eu_r : eu_r;
    eu_mag   = (eu_abs > 34'sh0ffffffff) ? 32'hffffffff : eu_abs[31:0];
    vmag     = vel_r[k_r][31] ? 32'(-33'(vel_r[k_r])) : vel_r[k_r];
    sq       = prod[63:FRAC_BITS];
    nine_eu2 = (POLY_W'(sq) << 3) + POLY_W'(sq);
    three_uu = (POLY_W'(uu_r) << 1) + POLY_W'(uu_r);
    poly_w   = (POLY_W'(1) <<< FRAC_BITS) + (POLY_W'(eu_r) <<< 1) + POLY_W'(eu_r)
             + $signed({1'b0, nine_eu2[POLY_W-1:1]})
             - $signed({1'b0, three_uu[POLY_W-1:1]});
    tq       = trunc_frac(prod);
    tabs     = tq[PROD_W-1] ? -tq : tq;
    qs       = neg_r ? -PROD_W'(div_q) : PROD_W'(div_q);
    diff     = 33'(f_cur) - 33'(fe_r);
    sub      = trunc_frac(prod);
    res_w    = PROD_W'(f_cur) - sub;
    mom_sel  = mom_r[k_r];
    mom_mag  = mom_sel[31] ? 32'(-33'(mom_sel)) : mom_sel;
    rho_mag  = rho_r[31] ? 32'(-33'(rho_r)) : rho_r;
    fe_xw    = PROD_W'(tabs) << weight_shift(idx_r);
    // high digit: x[35:18] / 27 and its remainder
    hq_p     = 37'(fe_x_r[35:18]) * 37'(RECIP_HI);
    rh_full  = fe_x_r[35:18] - (18'(hq_p[36:23]) * 18'd27);
    // low digit: (rem * 2^18 + x[17:0]) / 27
    lq_p     = 47'(fe_rl_r) * 47'(RECIP_LO);
    fe_qm    = fe_big_r ? 33'h1_0000_0000 : {1'b0, fe_qh_r, lq_p[45:28]};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (dir_count_r < DIR_W'(NDIR)) dir_count_nxt = dir_count_r + 1'b1;
          solid_seen_nxt = solid_seen_r | in_node_solid;
          if (in_last_of_node) begin
            solid_nxt      = solid_seen_r | in_node_solid;
            dir_count_nxt  = '0;
            solid_seen_nxt = 1'b0;
            idx_nxt        = '0;
            rho_acc_nxt    = '0;
            mom_acc_nxt    = '{default: '0};
            rho_nxt        = '0;
            vel_nxt        = '{default: '0};
            state_nxt      = (solid_seen_r | in_node_solid) ? S_D_RD : S_SUM_RD;
          end
        end
      end
      S_SUM_RD: state_nxt = S_SUM_ACC;
      S_SUM_ACC: begin
        rho_acc_nxt    = rho_acc_r + ACC_W'(f_cur);
        mom_acc_nxt[0] = mom_acc_r[0] + ACC_W'(dir_term(dv.x, f_cur));
        mom_acc_nxt[1] = mom_acc_r[1] + ACC_W'(dir_term(dv.y, f_cur));
        mom_acc_nxt[2] = mom_acc_r[2] + ACC_W'(dir_term(dv.z, f_cur));
        if (idx_r == LAST_DIR) begin
          idx_nxt   = '0;
          state_nxt = S_MOM;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SUM_RD;
        end
      end
      S_MOM: begin
        rho_nxt = sat32(PROD_W'(rho_acc_r));
        for (int i = 0; i < 3; i++) mom_nxt[i] = sat32(PROD_W'(mom_acc_r[i]));
        uu_nxt = '0;
        k_nxt  = '0;
        state_nxt = (sat32(PROD_W'(rho_acc_r)) == '0) ? S_UU_MUL : S_DIV_GO;
      end
      S_DIV_GO: begin
        div_go    = 1'b1;
        div_dvd   = DVD_W'(mom_mag) << FRAC_BITS;
        div_dvs   = rho_mag;
        neg_nxt   = mom_sel[31] ^ rho_r[31];
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          vel_nxt[k_r] = sat32(qs);
          if (k_r == 2'd2) begin
            k_nxt     = '0;
            state_nxt = S_UU_MUL;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_UU_MUL: begin
        mul_a     = MUL_W'(vmag);
        mul_b     = MUL_W'(vmag);
        state_nxt = S_UU_ACC;
      end
      S_UU_ACC: begin
        uu_nxt = uu_r + sq;
        if (k_r == 2'd2) begin
          idx_nxt   = '0;
          state_nxt = S_D_RD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_UU_MUL;
        end
      end
      S_D_RD: begin
        eu_nxt = dir_term(dv.x, vel_r[0]) + dir_term(dv.y, vel_r[1])
               + dir_term(dv.z, vel_r[2]);
        state_nxt = S_D_EU2;
      end
      S_D_EU2: begin
        if (solid_r) begin
          res_nxt    = f_cur;
          odir_nxt   = idx_r;
          strobe_nxt = 1'b1;
          idx_nxt    = idx_r + 1'b1;
          state_nxt  = (idx_r == LAST_DIR) ? S_IDLE : S_D_RD;
        end else begin
          mul_a     = MUL_W'(eu_mag);
          mul_b     = MUL_W'(eu_mag);
          state_nxt = S_D_POLY;
        end
      end
      S_D_POLY: begin
        poly_nxt  = sat32(PROD_W'(poly_w));
        state_nxt = S_D_RMUL;
      end
      S_D_RMUL: begin
        mul_a     = MUL_W'(rho_r);
        mul_b     = MUL_W'(poly_r);
        state_nxt = S_D_FEABS;
      end
      S_D_FEABS: begin
        // at or above 2^39 the weighted value saturates anyway
        fe_big_nxt = |fe_xw[PROD_W-1:39];
        fe_x_nxt   = fe_xw[38:3];
        neg_nxt    = tq[PROD_W-1];
        state_nxt  = S_D_FEHI;
      end
      S_D_FEHI: begin
        fe_qh_nxt = hq_p[36:23];
        fe_rl_nxt = {rh_full[4:0], fe_x_r[17:0]};
        state_nxt = S_D_FELO;
      end
      S_D_FELO: begin
        fe_nxt    = sat32(neg_r ? -PROD_W'(fe_qm) : PROD_W'(fe_qm));
        state_nxt = S_D_OMUL;
      end
      S_D_OMUL: begin
        mul_a     = diff;
        mul_b     = MUL_W'(relax_r);
        state_nxt = S_D_RES;
      end
      S_D_RES: begin
        res_nxt    = sat32(res_w);
        odir_nxt   = idx_r;
        strobe_nxt = 1'b1;
        idx_nxt    = idx_r + 1'b1;
        state_nxt  = (idx_r == LAST_DIR) ? S_IDLE : S_D_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dir_count_r  <= '0;
      solid_seen_r <= 1'b0;
      solid_r      <= 1'b0;
      idx_r        <= '0;
      k_r          <= '0;
      strobe_r     <= 1'b0;
      relax_r      <= RELAX_RESET;
    end else begin
      state_r      <= state_nxt;
      dir_count_r  <= dir_count_nxt;
      solid_seen_r <= solid_seen_nxt;
      solid_r      <= solid_nxt;
      idx_r        <= idx_nxt;
      k_r          <= k_nxt;
      strobe_r     <= strobe_nxt;
      if (cfg_we) relax_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rho_acc_r <= rho_acc_nxt;
    mom_acc_r <= mom_acc_nxt;
    rho_r     <= rho_nxt;
    mom_r     <= mom_nxt;
    vel_r     <= vel_nxt;
    uu_r      <= uu_nxt;
    eu_r      <= eu_nxt;
    poly_r    <= poly_nxt;
    fe_r      <= fe_nxt;
    neg_r     <= neg_nxt;
    res_r     <= res_nxt;
    odir_r    <= odir_nxt;
    fe_x_r    <= fe_x_nxt;
    fe_big_r  <= fe_big_nxt;
    fe_qh_r   <= fe_qh_nxt;
    fe_rl_r   <= fe_rl_nxt;
  end

  assign out_strobe          = strobe_r;
  assign out_collided_value  = res_r;
  assign out_direction_index = odir_r;
  assign out_density         = rho_r;
  assign out_vel_x           = vel_r[0];
  assign out_vel_y           = vel_r[1];
  assign out_vel_z           = vel_r[2];
  assign out_last_of_run     = strobe_r && (odir_r == LAST_DIR);

  // checks
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a node in progress");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_of_run |-> !busy)
    else $error("block still busy after last result");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_go |-> !div_busy)
    else $error("divider started while running");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    dir_count_r <= DIR_W'(NDIR))
    else $error("direction count out of range");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_WAIT) && !div_done |-> div_busy)
    else $error("waiting on an idle divider");

endmodule
